// ===== rtl/deq_pkg.sv =====
// Shared definitions for the double-ended queue: operation codes, result
// status codes and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package deq_pkg;

	// Default number of entries held by the ring buffer
	localparam int CAPACITY_DEF = 16;

	// Field widths fixed by the stream format
	localparam int MODE_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	// Operation codes carried on s_tuser
	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_LIST       = 3'd4;

	// Result status codes carried on m_tuser
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic              start;     // input transaction taken this cycle
		logic [MODE_W-1:0] mode;      // operation of that transaction
		logic              emit_ram;  // load result register from read data
		logic              next_rd;   // fetch the next listed entry
	} deq_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;     // no entries held
		logic out_free;  // result register can take a new result
		logic more;      // listing has entries left after the current one
	} deq_stat_t;

endpackage

`default_nettype wire

// ===== rtl/double_ended_queue_top.sv =====
// Double-ended queue of signed 32-bit values held in a ring buffer.
// Top level: joins the controller and the datapath. Depends on deq_pkg,
// deq_ctrl, deq_dpath and deq_ram.
//
// Usage:
//   Slave channel: s_tuser carries the operation (push front, push back,
//   pop front, pop back, list), s_tdata the value to push.
//   Master channel: one result per push or pop, one per held entry for a
//   listing (front first, tlast on the final one), or a single empty result
//   for a listing of an empty deque. Unused operation codes give no result.
//   m_tuser holds the status (ok, empty, full); data is zero unless ok.
// Timing and throughput:
//   A push or a failed pop answers in the cycle after acceptance, and the
//   next transaction may follow once the result register is free. A
//   successful pop first waits on the registered memory read. A listing
//   streams one entry a cycle from the memory read port while the output
//   is not stalled, and no new transaction is taken until it is done.
// Reset: arst_n empties the deque at once; entry memory is not cleared.
// Stall: a stalled result holds in the output register; s_tready drops
//   until it can be replaced, so nothing is lost.
`default_nettype none

module double_ended_queue_top #(
	parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] value
	input  wire logic [2:0]  s_tuser,   // [2:0] mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [31:0] data, [36:32] occupancy, [39:37] zero
	output logic [1:0]       m_tuser,   // [1:0] status
	output logic             m_tlast
);

	deq_pkg::deq_cmd_t  cmd;
	deq_pkg::deq_stat_t stat;
	logic [deq_pkg::VALUE_W-1:0] out_data;
	logic [deq_pkg::OCC_W-1:0]   out_occ;

	deq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.mode    (s_tuser),
		.stat    (stat),
		.cmd     (cmd)
	);

	deq_dpath #(
		.CAPACITY(CAPACITY)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (out_data),
		.out_status(m_tuser),
		.out_last  (m_tlast),
		.out_occ   (out_occ)
	);

	// Pack the result fields, padded to whole bytes
	assign m_tdata = {3'b000, out_occ, out_data};

endmodule

`default_nettype wire

// ===== rtl/deq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds its data when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/deq_ctrl.sv =====
// Controller for the double-ended queue: accepts transactions and sequences
// the memory read cycles of pops and listings.
// Depends on deq_pkg.
`default_nettype none

module deq_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [deq_pkg::MODE_W-1:0]   mode,
	input  wire deq_pkg::deq_stat_t           stat,
	output deq_pkg::deq_cmd_t                 cmd
);

	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_READ = 1'b1;

	logic [0:0] state_q;
	logic [0:0] state_d;
	logic       accept;
	logic       reads_ram;

	// Pops and listings of a non-empty deque go through the memory read
	assign reads_ram = !stat.empty &&
		(mode == deq_pkg::MODE_POP_FRONT || mode == deq_pkg::MODE_POP_BACK ||
		 mode == deq_pkg::MODE_LIST);

	assign s_tready = (state_q == S_IDLE) && stat.out_free;
	assign accept   = s_tvalid && s_tready;

	// Issue commands and pick the next state
	always_comb begin
		cmd          = '0;
		cmd.start    = accept;
		cmd.mode     = mode;
		state_d      = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && reads_ram) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (stat.out_free) begin
					cmd.emit_ram = 1'b1;
					cmd.next_rd  = stat.more;
					if (!stat.more) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	// A result taken from memory always follows a read-path transaction
	a_emit_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_READ) |-> $past(accept))
		else $error("read state entered without a transaction");
`endif

endmodule

`default_nettype wire

// ===== rtl/deq_dpath.sv =====
// Datapath of the double-ended queue: ring pointers, entry count, entry
// memory and the result register.
// Depends on deq_pkg and deq_ram.
`default_nettype none

module deq_dpath #(
	parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [deq_pkg::VALUE_W-1:0]    value,
	input  wire deq_pkg::deq_cmd_t              cmd,
	output deq_pkg::deq_stat_t                  stat,
	input  wire logic                           out_ready,
	output logic                                out_valid,
	output logic [deq_pkg::VALUE_W-1:0]         out_data,
	output logic [deq_pkg::STATUS_W-1:0]        out_status,
	output logic                                out_last,
	output logic [deq_pkg::OCC_W-1:0]           out_occ
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [AW-1:0] front_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] lcnt_q;
	logic          list_q;
	logic          valid_q;
	logic [deq_pkg::VALUE_W-1:0]  data_q;
	logic [deq_pkg::STATUS_W-1:0] status_q;
	logic          last_q;
	logic [deq_pkg::OCC_W-1:0]    occ_q;

	logic          full;
	logic          empty;
	logic          is_push;
	logic          is_pop;
	logic          is_list;
	logic          push_ok;
	logic          pop_ok;
	logic          list_ok;
	logic [AW-1:0] front_dec;
	logic [AW-1:0] front_inc;
	logic [AW-1:0] back_wr;
	logic [AW-1:0] back_rd;
	logic [AW-1:0] rptr_inc;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [deq_pkg::VALUE_W-1:0]  ram_rdata;
	logic          out_load;
	logic [deq_pkg::VALUE_W-1:0]  load_data;
	logic [deq_pkg::STATUS_W-1:0] load_status;
	logic          load_last;
	logic [CW-1:0] count_next;

	// Position base + off on the ring; for off up to the capacity the sum stays below twice the capacity
	function automatic logic [AW-1:0] ring(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(off);
		if (sum >= (CW+1)'(CAPACITY)) begin
			sum = sum - (CW+1)'(CAPACITY);
		end
		return AW'(sum);
	endfunction

	assign full  = (count_q == CW'(CAPACITY));
	assign empty = (count_q == '0);

	// Decode the operation of the incoming transaction
	assign is_push = (cmd.mode == deq_pkg::MODE_PUSH_FRONT) ||
		(cmd.mode == deq_pkg::MODE_PUSH_BACK);
	assign is_pop  = (cmd.mode == deq_pkg::MODE_POP_FRONT) ||
		(cmd.mode == deq_pkg::MODE_POP_BACK);
	assign is_list = (cmd.mode == deq_pkg::MODE_LIST);
	assign push_ok = cmd.start && is_push && !full;
	assign pop_ok  = cmd.start && is_pop && !empty;
	assign list_ok = cmd.start && is_list && !empty;

	// Ring neighbours of the pointers
	assign front_dec = (front_q == '0) ? AW'(CAPACITY - 1) : front_q - AW'(1);
	assign front_inc = ring(front_q, CW'(1));
	assign back_wr   = ring(front_q, count_q);
	assign back_rd   = ring(front_q, count_q - CW'(1));
	assign rptr_inc  = ring(rptr_q, CW'(1));

	// Memory port selection
	always_comb begin
		ram_we    = push_ok;
		ram_waddr = (cmd.mode == deq_pkg::MODE_PUSH_FRONT) ? front_dec : back_wr;
		ram_re    = pop_ok || list_ok || cmd.next_rd;
		if (cmd.next_rd) begin
			ram_raddr = rptr_q;
		end else if (cmd.mode == deq_pkg::MODE_POP_BACK) begin
			ram_raddr = back_rd;
		end else begin
			ram_raddr = front_q;
		end
	end

	deq_ram #(
		.WIDTH(deq_pkg::VALUE_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Result to load: immediate status, or an entry read from memory
	always_comb begin
		out_load    = 1'b0;
		load_data   = '0;
		load_status = deq_pkg::STAT_OK;
		load_last   = 1'b1;
		if (cmd.emit_ram) begin
			out_load  = 1'b1;
			load_data = ram_rdata;
			load_last = !stat.more;
		end else if (cmd.start && is_push) begin
			out_load    = 1'b1;
			load_status = full ? deq_pkg::STAT_FULL : deq_pkg::STAT_OK;
		end else if (cmd.start && (is_pop || is_list) && empty) begin
			out_load    = 1'b1;
			load_status = deq_pkg::STAT_EMPTY;
		end
	end

	always_comb begin
		count_next = count_q;
		if (push_ok) begin
			count_next = count_q + CW'(1);
		end else if (pop_ok) begin
			count_next = count_q - CW'(1);
		end
	end

	// Advance pointers, count and listing cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			rptr_q  <= '0;
			lcnt_q  <= '0;
			list_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			if (push_ok && cmd.mode == deq_pkg::MODE_PUSH_FRONT) begin
				front_q <= front_dec;
			end else if (pop_ok && cmd.mode == deq_pkg::MODE_POP_FRONT) begin
				front_q <= front_inc;
			end
			if (cmd.start) begin
				list_q <= list_ok;
				rptr_q <= front_inc;
				lcnt_q <= '0;
			end else if (cmd.next_rd) begin
				rptr_q <= rptr_inc;
				lcnt_q <= lcnt_q + CW'(1);
			end
		end
	end

	// Result register valid: set on load, drop when the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload; occupancy is taken after the operation
	always_ff @(posedge clk) begin
		if (out_load) begin
			data_q   <= load_data;
			status_q <= load_status;
			last_q   <= load_last;
			occ_q    <= deq_pkg::OCC_W'(count_next);
		end
	end

	assign stat = '{
		empty:    empty,
		out_free: !valid_q || out_ready,
		more:     list_q && (lcnt_q + CW'(1) != count_q)
	};

	assign out_valid  = valid_q;
	assign out_data   = data_q;
	assign out_status = status_q;
	assign out_last   = last_q;
	assign out_occ    = occ_q;

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CW'(front_q) < CW'(CAPACITY)) && (CW'(rptr_q) < CW'(CAPACITY)))
		else $error("ring pointer out of range");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && valid_q) |-> out_ready)
		else $error("pending result overwritten");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not grow the count");
`endif

endmodule

`default_nettype wire
